>>> hdl/ppro_pkg.sv
// Package for the planar pixel raster op core: payload structs,
// register indexes, mode codes and fixed geometry constants.
// No dependencies.
package ppro_pkg;

	localparam int unsigned ADDR_W  = 20;
	localparam int unsigned CFG_W   = 11;
	localparam int unsigned CFG_IDX_W = 3;

	// destination geometry; the byte span is 2**ADDR_W, so the wrap is the low bits
	localparam logic [10:0] MAX_PITCH = 11'd1024;
	localparam logic [10:0] MAX_ROWS  = 11'd1024;

	localparam logic [7:0] HI_NIBBLE = 8'hF0;
	localparam logic [3:0] LO_NIBBLE = 4'hF;

	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_X      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_Y      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOUR = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_MASK    = 3'd7;

	localparam logic [3:0] MODE_COPY         = 4'd0;
	localparam logic [3:0] MODE_MASKED_COPY  = 4'd1;
	localparam logic [3:0] MODE_TRANSP       = 4'd2;
	localparam logic [3:0] MODE_CLIP_TRANSP  = 4'd3;
	localparam logic [3:0] MODE_MONO         = 4'd4;
	localparam logic [3:0] MODE_MASKED_MONO  = 4'd5;
	localparam logic [3:0] MODE_XOR          = 4'd6;
	localparam logic [3:0] MODE_BLIT         = 4'd7;
	localparam logic [3:0] MODE_INV          = 4'd8;
	localparam logic [3:0] MODE_CLIP_INV     = 4'd9;

	typedef struct packed {
		logic [9:0] src_x;
		logic [9:0] src_y;
		logic       plane_transparent;
		logic       plane_intensity;
		logic       plane_red;
		logic       plane_green;
		logic       plane_blue;
		logic       mono_bit;
		logic [7:0] old_pixel;
	} item_t;

	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] dest_address;
		logic [7:0]        new_pixel;
	} result_t;

endpackage

>>> hdl/planar_pixel_raster_op_core.sv
// Planar pixel raster op core: per-pixel blit operation producing
// chunky destination writes. Depends on ppro_pkg.
//
// Usage:
//   item channel (item_valid / item_stall / item): one source pixel with its
//   plane bits, mono bit and the old destination byte. A transaction is
//   taken when item_valid is high and item_stall low.
//   result channel (result_valid / result_stall / result): write enable,
//   wrapped destination address and new byte, one per item, in order.
//   cfg port (cfg_we / cfg_index / cfg_data): register writes, taken at any
//   edge with cfg_we high; write only while no transaction is in flight.
// Pipeline: an accepted item goes into the input register, then through one pass
//   of address multiply-add and pixel select into the result register and
//   result_valid. Throughput: one item per cycle while result_stall is low, set by
//   the single multiplier pass between the two registers.
// Stall: when result_stall holds a waiting result, the input register still
//   takes one more item; item_stall rises only once both registers are full.
// Reset: arst_n clears the valid flags and loads the register defaults
//   (mode copy, offsets 0, pitch 320, clip 320 x 200, fill 0, mask 15).
module planar_pixel_raster_op_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ppro_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ppro_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  ppro_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output ppro_pkg::result_t                 result
);

	logic [3:0]  mode_q;
	logic [10:0] dest_x_q;
	logic [10:0] dest_y_q;
	logic [10:0] row_pitch_q;
	logic [10:0] clip_width_q;
	logic [10:0] clip_height_q;
	logic [7:0]  fill_colour_q;
	logic [3:0]  map_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= ppro_pkg::MODE_COPY;
			dest_x_q      <= 11'd0;
			dest_y_q      <= 11'd0;
			row_pitch_q   <= 11'd320;
			clip_width_q  <= 11'd320;
			clip_height_q <= 11'd200;
			fill_colour_q <= 8'd0;
			map_mask_q    <= 4'd15;
		end else if (cfg_we) begin
			case (cfg_index)
				ppro_pkg::REG_MODE:        mode_q        <= cfg_data[3:0];
				ppro_pkg::REG_DEST_X:      dest_x_q      <= cfg_data;
				ppro_pkg::REG_DEST_Y:      dest_y_q      <= cfg_data;
				ppro_pkg::REG_ROW_PITCH:   row_pitch_q   <= cfg_data;
				ppro_pkg::REG_CLIP_WIDTH:  clip_width_q  <= cfg_data;
				ppro_pkg::REG_CLIP_HEIGHT: clip_height_q <= cfg_data;
				ppro_pkg::REG_FILL_COLOUR: fill_colour_q <= cfg_data[7:0];
				ppro_pkg::REG_MAP_MASK:    map_mask_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic            valid_s1;
	ppro_pkg::item_t item_s1;
	logic            adv_out;
	logic            take_in;

	assign adv_out    = !result_valid || !result_stall;
	assign item_stall = valid_s1 && !adv_out;
	assign take_in    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (adv_out)
				result_valid <= valid_s1;
			if (take_in)
				valid_s1 <= 1'b1;
			else if (adv_out)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in)
			item_s1 <= item;
	end

	// address and pixel
	logic signed [11:0] col;
	logic signed [11:0] row;
	logic [10:0]        pitch;
	logic signed [23:0] row_off;
	logic signed [24:0] addr_full;
	logic               in_clip;
	logic [3:0]         index;
	logic [7:0]         mono_val;
	logic [7:0]         keep_old;
	logic               we;
	logic [7:0]         val;
	ppro_pkg::result_t  res_d;

	always_comb begin
		col = $signed({2'b00, item_s1.src_x}) + $signed({dest_x_q[10], dest_x_q});
		row = $signed({2'b00, item_s1.src_y}) + $signed({dest_y_q[10], dest_y_q});
		pitch = (row_pitch_q > ppro_pkg::MAX_PITCH) ? ppro_pkg::MAX_PITCH : row_pitch_q;
		row_off = row * $signed({1'b0, pitch});
		addr_full = $signed({row_off[23], row_off})
			+ $signed({{13{col[11]}}, col});
		in_clip = !col[11] && !row[11]
			&& (col[10:0] < clip_width_q) && (row[10:0] < clip_height_q);
		index = {item_s1.plane_intensity, item_s1.plane_red,
			item_s1.plane_green, item_s1.plane_blue};
		mono_val = item_s1.mono_bit ? fill_colour_q
			: (fill_colour_q & ppro_pkg::HI_NIBBLE);
		keep_old = item_s1.old_pixel & ~{4'b0000, map_mask_q};

		we  = 1'b0;
		val = item_s1.old_pixel;
		case (mode_q)
			ppro_pkg::MODE_COPY: begin
				we  = 1'b1;
				val = {4'b0000, index};
			end
			ppro_pkg::MODE_MASKED_COPY: begin
				we  = 1'b1;
				val = keep_old | {4'b0000, index & map_mask_q};
			end
			ppro_pkg::MODE_TRANSP: begin
				we  = !item_s1.plane_transparent;
				val = we ? {4'b0000, index} : item_s1.old_pixel;
			end
			ppro_pkg::MODE_CLIP_TRANSP: begin
				we  = !item_s1.plane_transparent && in_clip;
				val = we ? {4'b0000, index} : item_s1.old_pixel;
			end
			ppro_pkg::MODE_MONO: begin
				we  = 1'b1;
				val = mono_val;
			end
			ppro_pkg::MODE_MASKED_MONO: begin
				we  = 1'b1;
				val = keep_old
					| {4'b0000, mono_val[3:0] & map_mask_q & ppro_pkg::LO_NIBBLE};
			end
			ppro_pkg::MODE_XOR: begin
				we  = item_s1.mono_bit;
				val = we ? (item_s1.old_pixel ^ fill_colour_q) : item_s1.old_pixel;
			end
			ppro_pkg::MODE_BLIT: begin
				we  = item_s1.mono_bit;
				val = we ? fill_colour_q : item_s1.old_pixel;
			end
			ppro_pkg::MODE_INV: begin
				we  = !item_s1.mono_bit;
				val = we ? fill_colour_q : item_s1.old_pixel;
			end
			ppro_pkg::MODE_CLIP_INV: begin
				we  = !item_s1.mono_bit && in_clip;
				val = we ? fill_colour_q : item_s1.old_pixel;
			end
			default: begin
				we  = 1'b0;
				val = item_s1.old_pixel;
			end
		endcase

		res_d.write_enable = we;
		res_d.dest_address = addr_full[ppro_pkg::ADDR_W-1:0];
		res_d.new_pixel    = val;
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1)
			result <= res_d;
	end

endmodule
